### src/sri_pkg.sv
// Package: constants, types and the hash helper for the shuffled rotation index.
package sri_pkg;

  localparam int unsigned MaxSlots       = 16;
  localparam int unsigned DailyMinutes   = 1440;
  localparam int unsigned DailyStartHour = 4;
  localparam int unsigned SlotW          = $clog2(MaxSlots);
  localparam int unsigned CntW           = $clog2(MaxSlots + 1);

  localparam logic [31:0] DailyEdge  = 32'(DailyStartHour * 60);
  localparam logic [31:0] MixMulA    = 32'h7FEB352D;
  localparam logic [31:0] MixMulB    = 32'h846CA68B;
  localparam logic [31:0] SeedMul    = 32'h9E3779B9;
  localparam logic [31:0] SeedAdd    = 32'h5BD1E995;
  localparam logic [31:0] SeedZeroFx = 32'h01234567;

  localparam logic [1:0] RegSlotCount = 2'd0;
  localparam logic [1:0] RegInterval  = 2'd1;
  localparam logic [1:0] RegShuffle   = 2'd2;

  typedef enum logic [4:0] {
    StIdle, StDiv, StDivDone, StSeedMul, StMix0, StMixMul1, StMix1, StMixMul2,
    StMix2, StInit, StXs, StMod, StSwap, StPrevDone, StPick, StOut
  } state_e;

  // Request to the shared restoring divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] xs32(input logic [31:0] v);
    logic [31:0] a, b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

### src/sri_div.sv
// Shared 32-bit restoring divider, one quotient bit per cycle.
module sri_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sri_pkg::div_req_t req_i,
  output sri_pkg::div_rsp_t rsp_o
);
  import sri_pkg::*;

  logic [31:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in one dividend bit, subtract when it fits.
      if (!trial[32]) begin
        rem_d = trial[31:0];
      end else begin
        rem_d = {rem_q[30:0], quot_q[31]};
      end
      quot_d = {quot_q[30:0], ~trial[32]};
      cnt_d  = cnt_q - 6'd1;
      busy_d = (cnt_q != 6'd1);
    end
  end

  // rem_q can reach 33 bits transiently only if divisor is 0; never issued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

### src/shuffled_rotation_index.sv
// Top level: stream wrapper and sequencer of the shuffled rotation index.
//
//  channel | dir | contents
//  s_axis  | in  | tdata[31:0] now_minutes, [47:32] step_offset
//  m_axis  | out | tdata[3:0] slot_index, [7:4] zero
//  cfg     | in  | cfg_addr_i register index, cfg_data_i value
//
// The shared divider serves every division; each pass waits until it is idle.
// A word takes one pass through it when the interval is zero or
// the daily edge is not reached yet, two passes in sequential mode otherwise.
// Shuffled mode with 16 slots builds up to two rounds, each with a hash of the
// round number and 15 shuffle steps, and one round check, then the pick.
// Reset clears the registers to 0 and the sequencer to idle.
// s_axis_tready is low while a word is in work or its result waits.
module shuffled_rotation_index (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // now_minutes[31:0], step_offset[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // slot_index[3:0], zero fill[7:4]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import sri_pkg::*;

  logic [7:0]  slot_count_q;
  logic [15:0] interval_q;
  logic        shuffle_q;

  state_e      state_q, state_d;
  logic [31:0] k_q, k_d, rnd_q, rnd_d, st_q, st_d, tmp_q, tmp_d;
  logic [SlotW-1:0] pos_q, pos_d, i_q, i_d, last_q, last_d, res_q, res_d;
  logic [CntW-1:0]  n_q, n_d;
  logic        prev_q, prev_d;   // high while building the previous round
  logic [15:0] shake_q, shake_d;
  logic [SlotW-1:0] perm_q [MaxSlots];
  logic [SlotW-1:0] perm_d [MaxSlots];
  logic        out_v_q, out_v_d;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [31:0] now_w, pc, mul_a, mul_b, mul_p;
  logic [SlotW-1:0] j, ti;

  sri_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(8 - SlotW){1'b0}}, res_q};
  assign now_w         = s_axis_tdata[31:0];

  // Shared 32x32 multiplier, registered into tmp.
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= '0;
      interval_q   <= '0;
      shuffle_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegSlotCount: slot_count_q <= cfg_data_i[7:0];
        RegInterval:  interval_q   <= cfg_data_i;
        RegShuffle:   shuffle_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    k_d = k_q; rnd_d = rnd_q; st_d = st_q; tmp_d = tmp_q;
    pos_d = pos_q; i_d = i_q; last_d = last_q; res_d = res_q;
    n_d = n_q; prev_d = prev_q; shake_d = shake_q;
    perm_d = perm_q;
    out_v_d = out_v_q && !m_axis_tready;
    dreq = '0;
    mul_a = st_q; mul_b = MixMulA;
    pc = '0;
    j  = drsp.rem[SlotW-1:0];
    ti = perm_q[i_q];
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          shake_d = s_axis_tdata[47:32];
          n_d = (slot_count_q > 8'(MaxSlots)) ? CntW'(MaxSlots) : CntW'(slot_count_q);
          if (slot_count_q == 8'd0) begin
            res_d = '0;
            state_d = StOut;
          end else if (interval_q == 16'd0) begin
            k_d = {16'd0, s_axis_tdata[47:32]};
            state_d = StDivDone;
            dreq.start = 1'b1; dreq.dividend = k_d;
            dreq.divisor = {{(32 - CntW){1'b0}}, n_d};
          end else if (interval_q == 16'(DailyMinutes)) begin
            if (now_w < DailyEdge) begin
              k_d = {16'd0, s_axis_tdata[47:32]};
              state_d = StDivDone;
              dreq.start = 1'b1; dreq.dividend = k_d;
              dreq.divisor = {{(32 - CntW){1'b0}}, n_d};
            end else begin
              rnd_d = 32'd1;   // marks the +1 of the daily count
              state_d = StDiv;
              dreq.start = 1'b1; dreq.dividend = now_w - DailyEdge;
              dreq.divisor = 32'(DailyMinutes);
            end
          end else begin
            rnd_d = 32'd0;
            state_d = StDiv;
            dreq.start = 1'b1; dreq.dividend = now_w;
            dreq.divisor = {16'd0, interval_q};
          end
        end
      end
      StDiv: begin
        if (!drsp.busy) begin
          pc = drsp.quot + rnd_q;
          k_d = pc + {16'd0, shake_q};
          dreq.start = 1'b1; dreq.dividend = k_d;
          dreq.divisor = {{(32 - CntW){1'b0}}, n_q};
          state_d = StDivDone;
        end
      end
      StDivDone: begin
        if (!drsp.busy) begin
          pos_d = drsp.rem[SlotW-1:0];
          rnd_d = drsp.quot;
          if (!shuffle_q || n_q <= CntW'(2)) begin
            res_d = drsp.rem[SlotW-1:0];
            state_d = StOut;
          end else begin
            // Build the previous round first when there is one.
            prev_d = (drsp.quot != 32'd0);
            state_d = StSeedMul;
          end
        end
      end
      StSeedMul: begin
        mul_a = prev_q ? rnd_q - 32'd1 : rnd_q; mul_b = SeedMul;
        tmp_d = mul_p + SeedAdd;
        state_d = StMix0;
      end
      StMix0: begin
        st_d = tmp_q ^ (tmp_q >> 16);
        state_d = StMixMul1;
      end
      StMixMul1: begin
        mul_a = st_q; mul_b = MixMulA;
        tmp_d = mul_p;
        state_d = StMix1;
      end
      StMix1: begin
        st_d = tmp_q ^ (tmp_q >> 15);
        state_d = StMixMul2;
      end
      StMixMul2: begin
        mul_a = st_q; mul_b = MixMulB;
        tmp_d = mul_p;
        state_d = StMix2;
      end
      StMix2: begin
        st_d = tmp_q ^ (tmp_q >> 16);
        if (st_d == 32'd0) st_d = SeedZeroFx;
        state_d = StInit;
      end
      StInit: begin
        for (int e = 0; e < MaxSlots; e++) perm_d[e] = SlotW'(e);
        i_d = SlotW'(n_q - CntW'(1));
        state_d = StXs;
      end
      StXs: begin
        // Advance the generator and reduce it modulo i+1.
        st_d = xs32(st_q);
        dreq.start = 1'b1; dreq.dividend = st_d;
        dreq.divisor = {{(32 - SlotW){1'b0}}, i_q} + 32'd1;
        state_d = StMod;
      end
      StMod: begin
        if (!drsp.busy) begin
          perm_d[i_q] = perm_q[j];
          perm_d[j]   = ti;
          state_d = StSwap;
        end
      end
      StSwap: begin
        i_d = i_q - SlotW'(1);
        state_d = (i_q == SlotW'(1)) ? StPrevDone : StXs;
      end
      StPrevDone: begin
        if (prev_q) begin
          // Hold the last entry of the previous round, then build the current one.
          last_d = perm_q[SlotW'(n_q - CntW'(1))];
          prev_d = 1'b0;
          state_d = StSeedMul;
        end else begin
          state_d = StPick;
        end
      end
      StPick: begin
        if (rnd_q != 32'd0 && perm_q[0] == last_q) begin
          res_d = (pos_q == SlotW'(0)) ? perm_q[1] :
                  (pos_q == SlotW'(1)) ? perm_q[0] : perm_q[pos_q];
        end else begin
          res_d = perm_q[pos_q];
        end
        state_d = StOut;
      end
      StOut: begin
        if (!out_v_q) begin
          out_v_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      prev_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      prev_q  <= prev_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; rnd_q <= rnd_d; st_q <= st_d; tmp_q <= tmp_d;
    pos_q <= pos_d; last_q <= last_d; res_q <= res_d;
    n_q <= n_d; shake_q <= shake_d;
    perm_q <= perm_d;
  end

endmodule

### src/sri_checker.sv
// Port checker for the shuffled rotation index, bound to the top level.
module sri_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import sri_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result waits");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:SlotW] == '0)
    else $error("padding bits set");

endmodule

bind shuffled_rotation_index sri_checker u_sri_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### dv/shuffled_rotation_index_tb.sv
// Testbench for the shuffled rotation index: directed and random minute queries.
module shuffled_rotation_index_tb;
  import sri_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // now_minutes[31:0], step_offset[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // slot_index[3:0], zero fill[7:4]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;

  localparam int unsigned WatchdogLimit = 200000;

  // Model copy of the registers.
  logic [7:0]  slots_q;
  logic [15:0] interval_q;
  logic        shuffle_q;

  logic [3:0] slot_fifo[$];
  int unsigned mismatch_cnt;
  int unsigned word_cnt;
  int unsigned result_cnt;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  shuffled_rotation_index dut (.*);

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_cnt++;
  endtask

  // Randomize receiver back-pressure each cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (slot_fifo.size() == 0) begin
        report_mismatch($sformatf("unexpected slot word %h", m_axis_tdata));
      end else begin
        logic [3:0] exp_slot;
        exp_slot = slot_fifo.pop_front();
        if (m_axis_tdata[3:0] !== exp_slot || m_axis_tdata[7:4] !== 4'h0)
          report_mismatch($sformatf("slot got %h exp %h", m_axis_tdata, exp_slot));
      end
    end
  end

  // Watchdog: count cycles with no handshake at all.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired, %0d results pending", slot_fifo.size());
        $display("shuffled_rotation_index_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [31:0] period_of(input logic [31:0] now);
    if (interval_q == 16'd0) return 32'd0;
    if (interval_q == 16'(DailyMinutes)) begin
      if (now < DailyEdge) return 32'd0;
      return (now - DailyEdge) / DailyMinutes + 32'd1;
    end
    return now / {16'd0, interval_q};
  endfunction

  function automatic logic [31:0] lowbias(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * MixMulA;
    v = v ^ (v >> 15);
    v = v * MixMulB;
    return v ^ (v >> 16);
  endfunction

  // Fisher-Yates order of 0..n-1 seeded from the round number.
  function automatic void shuffle_round(input logic [31:0] rnd, input int unsigned n,
                                        output logic [3:0] order[16]);
    logic [31:0] st;
    logic [31:0] j;
    logic [3:0]  t;
    for (int i = 0; i < 16; i++) order[i] = 4'(i);
    st = lowbias(rnd * SeedMul + SeedAdd);
    if (st == 32'd0) st = SeedZeroFx;
    for (int i = n - 1; i > 0; i--) begin
      st = st ^ (st << 13);
      st = st ^ (st >> 17);
      st = st ^ (st << 5);
      j = (st % (i + 1)) & 32'hF;
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endfunction

  function automatic logic [3:0] predict_slot(input logic [31:0] now,
                                              input logic [15:0] shake);
    int unsigned n;
    logic [31:0] k, rnd;
    logic [3:0]  cur[16], prev[16], t;
    n = slots_q;
    if (n == 0) return 4'd0;
    if (n > MaxSlots) n = MaxSlots;
    k = period_of(now) + {16'd0, shake};
    if (!shuffle_q || n <= 2) return 4'(k % n);
    rnd = k / n;
    shuffle_round(rnd, n, cur);
    if (rnd > 0) begin
      shuffle_round(rnd - 1, n, prev);
      if (cur[0] == prev[n - 1]) begin
        t = cur[0];
        cur[0] = cur[1];
        cur[1] = t;
      end
    end
    return cur[k % n];
  endfunction

  // Valid stays high after the handshake; idling or draining drops it.
  task automatic send_query(input logic [31:0] now, input logic [15:0] shake);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {shake, now};
    slot_fifo.push_back(predict_slot(now, shake));
    do @(posedge clk_i); while (!s_axis_tready);
    word_cnt++;
  endtask

  // Wait for all results, then settle before touching registers.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (slot_fifo.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegSlotCount: slots_q    = val[7:0];
      RegInterval:  interval_q = val;
      RegShuffle:   shuffle_q  = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] n, input logic [15:0] ivl, input logic shf);
    drain();
    write_reg(RegSlotCount, {8'd0, n});
    write_reg(RegInterval, ivl);
    write_reg(RegShuffle, {15'd0, shf});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_now();
    case ($urandom_range(3))
      0: return $urandom_range(600);                 // around the morning edge
      1: return 32'hFFFF_FFFF - $urandom_range(50);  // near wrap
      default: return $urandom;
    endcase
  endfunction

  // Reset defaults: zero slots always answer zero.
  task automatic test_reset_defaults;
    send_query(32'hFFFF_FFFF, 16'hFFFF);
    send_query(32'd0, 16'd0);
  endtask

  // Field extremes, the daily edge, offset wrap and slot clamping.
  task automatic test_directed;
    configure(8'd7, 16'(DailyMinutes), 1'b0);
    send_query(DailyEdge - 1, 16'd0);
    send_query(DailyEdge, 16'd0);
    send_query(DailyEdge + DailyMinutes, 16'd3);
    send_query(32'hFFFF_FFFF, 16'hFFFF);
    configure(8'd255, 16'd1, 1'b1);                   // clamped to max slots
    send_query(32'hFFFF_FFFF, 16'hFFFF);              // count wraps
    send_query(32'd0, 16'd0);                         // first round, no swap
    send_query(32'd16, 16'd0);
    send_query(32'd31, 16'd1);
    configure(8'd2, 16'hFFFF, 1'b1);                  // two slots stay sequential
    send_query(32'hFFFF_FFFF, 16'd1);
    send_query(32'h0001_0000, 16'd0);
    configure(8'd3, 16'd0, 1'b1);                     // interval zero never rotates
    send_query(32'h5555_5555, 16'hAAAA);
    send_query(32'hAAAA_AAAA, 16'h5555);
    configure(8'd1, 16'd60, 1'b1);
    send_query(32'd12345, 16'd77);
  endtask

  // Random settings and queries, idling per phase.
  task automatic test_random(input int unsigned count, input int unsigned s_pct,
                             input int unsigned r_pct);
    logic [7:0]  n;
    logic [15:0] ivl;
    drain();
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int b = 0; b < count / 12; b++) begin
      n = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(16));
      case ($urandom_range(4))
        0: ivl = 16'(DailyMinutes);
        1: ivl = 16'($urandom_range(3));
        2: ivl = 16'hFFFF;
        default: ivl = 16'($urandom);
      endcase
      configure(n, ivl, 1'($urandom_range(3) != 0));
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(4) == 0) send_query(rand_now(), 16'($urandom_range(40)));
        else send_query(rand_now(), 16'($urandom));
      end
    end
  endtask

  initial begin
    slots_q = '0;
    interval_q = '0;
    shuffle_q = 1'b0;
    mismatch_cnt = 0;
    word_cnt = 0;
    result_cnt = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random(144, 0, 0);
    test_random(144, 47, 0);
    test_random(144, 0, 47);
    test_random(144, 15, 15);
    drain();
    $display("covered %0d queries, %0d slot results, sequential and shuffled modes,",
             word_cnt, result_cnt);
    $display("daily, zero and plain intervals under four idle patterns");
    if (mismatch_cnt == 0) begin
      $display("shuffled_rotation_index_tb OK");
    end else begin
      $display("shuffled_rotation_index_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
src/sri_pkg.sv
src/sri_div.sv
src/shuffled_rotation_index.sv
src/sri_checker.sv
dv/shuffled_rotation_index_tb.sv
